// ----- rtl/pcpf_pkg.sv -----
// Shared constants for the pitch-class prime-form pipeline.
`default_nettype none

package pcpf_pkg;

    // Default number of pitch classes per octave.
    localparam int MODULUS_DEF = 12;

    // Fixed field widths of the stream payload.
    localparam int MASK_W = 12;
    localparam int CARD_W = 4;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // Number of rotation candidates reduced together in the first minimum stage.
    localparam int GROUP = 4;

endpackage

`default_nettype wire

// ----- rtl/pitch_class_prime_form.sv -----
// Pitch-class set prime form: five-stage pipeline from set mask to prime-form mask.
//
// Takes one pitch-class set per cycle while the output is ready and returns one prime
// form per input, in order, through five register stages (input masking and inversion,
// rotation candidates, grouped minimum, final minimum, choice between the set and its
// inversion). Each rotation is judged by its transposed mask read as a number, so the
// smallest mask is the normal form; the set and its inversion are then compared at their
// lowest differing pitch class. Backpressure on the result side stalls only the stages
// that hold data, so bubbles are squeezed out.
`default_nettype none

module pitch_class_prime_form
    import pcpf_pkg::*;
#(
    parameter int MODULUS = MODULUS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [11:0] pc_mask, [15:12] zero
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // [11:0] prime_mask, [15:12] cardinality
    output logic                      m_tuser    // [0] from_inversion
);

    localparam int MW     = MODULUS;
    localparam int NG     = (MODULUS + GROUP - 1) / GROUP;
    localparam int CAND_N = NG * GROUP;

    // Stage enables and valid bits.
    logic en1, en2, en3, en4, en5;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // Stage 1: masked set, its inversion and its size.
    logic [MW-1:0]     set_reg, set_next;
    logic [MW-1:0]     inv_reg, inv_next;
    logic [CARD_W-1:0] card1_reg, card1_next;
    logic [MW+MASK_W-1:0] in_ext;

    // Stage 2: one candidate per rotation, all ones where the rotation is not a member.
    logic [MW-1:0]     cset_reg  [CAND_N];
    logic [MW-1:0]     cset_next [CAND_N];
    logic [MW-1:0]     cinv_reg  [CAND_N];
    logic [MW-1:0]     cinv_next [CAND_N];
    logic [CARD_W-1:0] card2_reg;

    // Stage 3: minimum of each group of candidates.
    logic [MW-1:0]     gset_reg  [NG];
    logic [MW-1:0]     gset_next [NG];
    logic [MW-1:0]     ginv_reg  [NG];
    logic [MW-1:0]     ginv_next [NG];
    logic [CARD_W-1:0] card3_reg;

    // Stage 4: normal forms of the set and of its inversion.
    logic [MW-1:0]     nset_reg, nset_next;
    logic [MW-1:0]     ninv_reg, ninv_next;
    logic [CARD_W-1:0] card4_reg;

    // Stage 5: result.
    logic [MASK_W-1:0] prime_reg, prime_next;
    logic [CARD_W-1:0] card5_reg;
    logic              use_inv_reg, use_inv_next;

    logic [MW-1:0]        diff;
    logic [MW-1:0]        low_diff;
    logic                 set_wins;
    logic [MW-1:0]        chosen;
    logic [MW+MASK_W-1:0] chosen_ext;

    assign en5 = !v5_reg || m_tready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= s_tvalid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
            if (en4) begin
                v4_reg <= v3_reg;
            end
            if (en5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    // Stage 1: bits at or above the modulus are dropped; class k maps to -k.
    assign in_ext = {{MW{1'b0}}, s_tdata[MASK_W-1:0]};

    always_comb begin
        set_next   = in_ext[MW-1:0];
        inv_next   = '0;
        card1_next = '0;
        for (int k = 0; k < MW; k++) begin
            inv_next[(k == 0) ? 0 : MW - k] = set_next[k];
            card1_next = card1_next + CARD_W'(set_next[k]);
        end
    end

    // Stage 2: rotation r moves class r down to 0.
    always_comb begin
        for (int r = 0; r < CAND_N; r++) begin
            cset_next[r] = '1;
            cinv_next[r] = '1;
        end
        for (int r = 0; r < MW; r++) begin
            for (int j = 0; j < MW; j++) begin
                cset_next[r][j] = set_reg[(j + r >= MW) ? j + r - MW : j + r];
                cinv_next[r][j] = inv_reg[(j + r >= MW) ? j + r - MW : j + r];
            end
            if (!set_reg[r]) begin
                cset_next[r] = '1;
            end
            if (!inv_reg[r]) begin
                cinv_next[r] = '1;
            end
        end
    end

    // Stage 3: minimum within each group.
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            gset_next[g] = cset_reg[g * GROUP];
            ginv_next[g] = cinv_reg[g * GROUP];
            for (int e = 1; e < GROUP; e++) begin
                if (cset_reg[g * GROUP + e] < gset_next[g]) begin
                    gset_next[g] = cset_reg[g * GROUP + e];
                end
                if (cinv_reg[g * GROUP + e] < ginv_next[g]) begin
                    ginv_next[g] = cinv_reg[g * GROUP + e];
                end
            end
        end
    end

    // Stage 4: minimum over the groups.
    always_comb begin
        nset_next = gset_reg[0];
        ninv_next = ginv_reg[0];
        for (int g = 1; g < NG; g++) begin
            if (gset_reg[g] < nset_next) begin
                nset_next = gset_reg[g];
            end
            if (ginv_reg[g] < ninv_next) begin
                ninv_next = ginv_reg[g];
            end
        end
    end

    // Stage 5: the set's own form wins only when it holds the lowest differing class.
    // An empty set reduces to all ones on both sides and is forced to zero.
    assign diff       = nset_reg ^ ninv_reg;
    assign low_diff   = diff & (~diff + MW'(1));
    assign set_wins   = |(nset_reg & low_diff);
    assign chosen     = set_wins ? nset_reg : ninv_reg;
    assign chosen_ext = {{MASK_W{1'b0}}, chosen};

    always_comb begin
        if (card4_reg == '0) begin
            prime_next   = '0;
            use_inv_next = 1'b0;
        end else begin
            prime_next   = chosen_ext[MASK_W-1:0];
            use_inv_next = !set_wins;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            set_reg   <= set_next;
            inv_reg   <= inv_next;
            card1_reg <= card1_next;
        end
        if (en2) begin
            for (int r = 0; r < CAND_N; r++) begin
                cset_reg[r] <= cset_next[r];
                cinv_reg[r] <= cinv_next[r];
            end
            card2_reg <= card1_reg;
        end
        if (en3) begin
            for (int g = 0; g < NG; g++) begin
                gset_reg[g] <= gset_next[g];
                ginv_reg[g] <= ginv_next[g];
            end
            card3_reg <= card2_reg;
        end
        if (en4) begin
            nset_reg  <= nset_next;
            ninv_reg  <= ninv_next;
            card4_reg <= card3_reg;
        end
        if (en5) begin
            prime_reg   <= prime_next;
            use_inv_reg <= use_inv_next;
            card5_reg   <= card4_reg;
        end
    end

    assign m_tvalid = v5_reg;
    assign m_tdata  = {card5_reg, prime_reg};
    assign m_tuser  = use_inv_reg;

endmodule

`default_nettype wire
